### design/capt_pkg.sv
// types and constants shared by the capture / apwm timer register block
package capt_pkg;

    // operation codes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    // register indexes
    localparam logic [3:0] REG_COUNTER  = 4'd0;
    localparam logic [3:0] REG_PHASE    = 4'd1;
    localparam logic [3:0] REG_CAP1     = 4'd2;
    localparam logic [3:0] REG_CAP2     = 4'd3;
    localparam logic [3:0] REG_CAP3     = 4'd4;
    localparam logic [3:0] REG_CAP4     = 4'd5;
    localparam logic [3:0] REG_CTL1     = 4'd6;
    localparam logic [3:0] REG_CTL2     = 4'd7;
    localparam logic [3:0] REG_INTEN    = 4'd8;
    localparam logic [3:0] REG_FLAGS    = 4'd9;
    localparam logic [3:0] REG_CLEAR    = 4'd10;
    localparam logic [3:0] REG_FORCE    = 4'd11;
    localparam logic [3:0] REG_REVISION = 4'd12;

    // control two bit positions
    localparam int CTL2_RUN_BIT  = 4;
    localparam int CTL2_APWM_BIT = 9;

    // event flag bit positions
    localparam int EV_OVF_BIT = 5;
    localparam int EV_PRD_BIT = 6;
    localparam int EV_CMP_BIT = 7;

    localparam logic [15:0] EV_CEVT_MASK = 16'h001E;
    localparam logic [15:0] EV_APWM_MASK = 16'h00C0;

    localparam logic [31:0] CNT_ALL_ONES = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0]  op;
        logic [3:0]  reg_index;
        logic [31:0] write_data;
    } capt_in_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        irq_pulse;
        logic        bad_index;
    } capt_out_t;

endpackage

### design/capture_apwm_timer_regs.sv
// capture / apwm timer register block: one tick, read or write per transfer
// Throughput is one item per clock while neither side stalls. An accepted item enters an input
// register; once the output register is free or being emptied, its tick, read or write is applied
// to the timer state in one step (counter increment and the compare and period matches) and its
// result is loaded into the output register. Either side may stall; the input register
// still takes a new item whenever the output register is free or being emptied.
module capture_apwm_timer_regs (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  capt_pkg::capt_in_t in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output capt_pkg::capt_out_t out_data,
    input  logic               cfg_wr_en,
    input  logic [31:0]        cfg_wr_data
);
    import capt_pkg::*;

    logic        s1_valid_reg;
    capt_in_t    s1_data_reg;
    logic        out_valid_reg;
    capt_out_t   out_data_reg;
    capt_out_t   out_data_next;

    logic [31:0] revision_reg;
    logic [31:0] counter_reg, counter_next;
    logic [31:0] phase_reg, phase_next;
    logic [31:0] cap_reg [4];
    logic [31:0] cap_next [4];
    logic [15:0] ctl1_reg, ctl1_next;
    logic [15:0] ctl2_reg, ctl2_next;
    logic [15:0] inten_reg, inten_next;
    logic [15:0] flags_reg, flags_next;
    logic [15:0] clear_reg, clear_next;
    logic [15:0] force_reg, force_next;

    logic        advance;
    logic        proc;
    logic        apwm;
    logic        run;
    logic [31:0] counter_inc;
    logic        cmp_hit;
    logic        prd_hit;
    logic [15:0] wd_low;

    assign advance   = !out_valid_reg || out_ready;
    assign proc      = s1_valid_reg && advance;
    assign in_ready  = !s1_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign apwm        = ctl2_reg[CTL2_APWM_BIT];
    assign run         = ctl2_reg[CTL2_RUN_BIT];
    assign counter_inc = counter_reg + 32'd1;
    assign cmp_hit     = (counter_inc == cap_reg[3]) && !flags_reg[EV_CMP_BIT];
    assign prd_hit     = (counter_inc == cap_reg[2]) && !flags_reg[EV_PRD_BIT];
    assign wd_low      = s1_data_reg.write_data[15:0];

    always_comb
    begin
        counter_next  = counter_reg;
        phase_next    = phase_reg;
        cap_next      = cap_reg;
        ctl1_next     = ctl1_reg;
        ctl2_next     = ctl2_reg;
        inten_next    = inten_reg;
        flags_next    = flags_reg;
        clear_next    = clear_reg;
        force_next    = force_reg;
        out_data_next = '0;

        unique case (s1_data_reg.op)
            OP_TICK:
            begin
                if (apwm)
                begin
                    if (run)
                    begin
                        counter_next = prd_hit ? '0 : counter_inc;
                        if (cmp_hit)
                            flags_next[EV_CMP_BIT] = 1'b1;
                        if (prd_hit)
                            flags_next[EV_PRD_BIT] = 1'b1;
                        out_data_next.irq_pulse = (cmp_hit && inten_reg[EV_CMP_BIT])
                            || (prd_hit && inten_reg[EV_PRD_BIT])
                            || (|(force_reg & inten_reg & EV_APWM_MASK));
                    end
                end
                else
                begin
                    out_data_next.irq_pulse = (|(force_reg & inten_reg & EV_CEVT_MASK))
                        || ((force_reg[EV_OVF_BIT] || counter_reg == CNT_ALL_ONES)
                            && inten_reg[EV_OVF_BIT]);
                end
            end
            OP_READ:
            begin
                unique case (s1_data_reg.reg_index)
                    REG_COUNTER:  out_data_next.read_data = counter_reg;
                    REG_PHASE:    out_data_next.read_data = phase_reg;
                    REG_CAP1:     out_data_next.read_data = cap_reg[0];
                    REG_CAP2:     out_data_next.read_data = cap_reg[1];
                    REG_CAP3:     out_data_next.read_data = cap_reg[2];
                    REG_CAP4:     out_data_next.read_data = cap_reg[3];
                    REG_CTL1:     out_data_next.read_data = {16'd0, ctl1_reg};
                    REG_CTL2:     out_data_next.read_data = {16'd0, ctl2_reg};
                    REG_INTEN:    out_data_next.read_data = {16'd0, inten_reg};
                    REG_FLAGS:    out_data_next.read_data = {16'd0, flags_reg};
                    REG_CLEAR:    out_data_next.read_data = {16'd0, clear_reg};
                    REG_FORCE:    out_data_next.read_data = {16'd0, force_reg};
                    REG_REVISION: out_data_next.read_data = revision_reg;
                    default:      out_data_next.bad_index = 1'b1;
                endcase
            end
            OP_WRITE:
            begin
                unique case (s1_data_reg.reg_index)
                    REG_COUNTER: counter_next = s1_data_reg.write_data;
                    REG_PHASE:   phase_next   = s1_data_reg.write_data;
                    // in apwm mode the shadow pairs cap1/cap3 and cap2/cap4 mirror
                    REG_CAP1:
                    begin
                        cap_next[0] = s1_data_reg.write_data;
                        if (apwm)
                            cap_next[2] = s1_data_reg.write_data;
                    end
                    REG_CAP2:
                    begin
                        cap_next[1] = s1_data_reg.write_data;
                        if (apwm)
                            cap_next[3] = s1_data_reg.write_data;
                    end
                    REG_CAP3:
                    begin
                        cap_next[2] = s1_data_reg.write_data;
                        if (apwm)
                            cap_next[0] = s1_data_reg.write_data;
                    end
                    REG_CAP4:
                    begin
                        cap_next[3] = s1_data_reg.write_data;
                        if (apwm)
                            cap_next[1] = s1_data_reg.write_data;
                    end
                    REG_CTL1:    ctl1_next  = wd_low;
                    REG_CTL2:    ctl2_next  = wd_low;
                    REG_INTEN:   inten_next = wd_low;
                    REG_FLAGS:   flags_next = wd_low;
                    REG_CLEAR:
                    begin
                        clear_next = wd_low;
                        flags_next = flags_reg & ~wd_low;
                    end
                    REG_FORCE:   force_next = wd_low;
                    // revision is read only, so it lands here too
                    default:     out_data_next.bad_index = 1'b1;
                endcase
            end
            default:
            begin
                // unknown op changes nothing and returns all zero
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (proc)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            s1_data_reg <= in_data;
        if (proc)
            out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            revision_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            revision_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg <= '0;
            phase_reg   <= '0;
            cap_reg     <= '{default: '0};
            ctl1_reg    <= '0;
            ctl2_reg    <= '0;
            inten_reg   <= '0;
            flags_reg   <= '0;
            clear_reg   <= '0;
            force_reg   <= '0;
        end
        else if (proc)
        begin
            counter_reg <= counter_next;
            phase_reg   <= phase_next;
            cap_reg     <= cap_next;
            ctl1_reg    <= ctl1_next;
            ctl2_reg    <= ctl2_next;
            inten_reg   <= inten_next;
            flags_reg   <= flags_next;
            clear_reg   <= clear_next;
            force_reg   <= force_next;
        end
    end

`ifndef SYNTH
    // a result never carries both an interrupt and an index error
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_data_reg.irq_pulse && out_data_reg.bad_index))
        else $error("irq and bad index set together");

    // a stopped apwm counter holds across a tick
    assert property (@(posedge clk) disable iff (!rst_n)
        (proc && s1_data_reg.op == OP_TICK && apwm && !run) |=> $stable(counter_reg))
        else $error("stopped counter moved");

    // capture mode ticks never touch the counter
    assert property (@(posedge clk) disable iff (!rst_n)
        (proc && s1_data_reg.op == OP_TICK && !apwm) |=> $stable(counter_reg))
        else $error("counter moved in capture mode");

    // a period match restarts the counter from zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (proc && s1_data_reg.op == OP_TICK && apwm && run && prd_hit)
        |=> (counter_reg == '0 && flags_reg[EV_PRD_BIT]))
        else $error("period match did not restart counter");

    // a read of a known register is never flagged bad
    assert property (@(posedge clk) disable iff (!rst_n)
        (proc && s1_data_reg.op == OP_READ && s1_data_reg.reg_index <= REG_REVISION)
        |=> (out_valid_reg && !out_data_reg.bad_index))
        else $error("good read flagged bad");
`endif

endmodule

### tb/capture_apwm_timer_regs_tb.sv
// self-checking testbench for the capture / apwm timer register block
`timescale 1ns / 1ps

module capture_apwm_timer_regs_tb;
    import capt_pkg::*;

    localparam logic [1:0]  OP_UNUSED       = 2'd3;
    localparam logic [3:0]  REG_FIRST_HOLE  = 4'd13;
    localparam logic [3:0]  REG_LAST_HOLE   = 4'd15;
    localparam logic [15:0] CTL2_APWM_RUN   = 16'(1 << CTL2_APWM_BIT) | 16'(1 << CTL2_RUN_BIT);
    localparam int          N_DIRECTED      = 25;
    localparam int          N_RANDOM_PHASE  = 463;
    localparam int          WATCHDOG_LIMIT  = 1000;
    localparam int          REPORT_LIMIT    = 10;

    typedef struct packed {
        logic [1:0]  op;
        logic [3:0]  reg_index;
        logic [31:0] write_data;
        logic        fixed;
        logic [31:0] read_data;
        logic        irq_pulse;
        logic        bad_index;
    } dir_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    capt_in_t   in_data = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    capt_out_t  out_data;
    logic       cfg_wr_en = 1'b0;
    logic [31:0] cfg_wr_data = '0;

    // predicted register state
    logic [31:0] pr_cnt;
    logic [31:0] pr_phase;
    logic [31:0] pr_cap [4];
    logic [15:0] pr_ctl1;
    logic [15:0] pr_ctl2;
    logic [15:0] pr_ien;
    logic [15:0] pr_flags;
    logic [15:0] pr_clear;
    logic [15:0] pr_force;
    logic [31:0] pr_rev;

    capt_out_t   due_results [$];
    int          mismatches = 0;
    int          quiet_cycles = 0;
    int          sink_hold = 0;
    bit          idling = 1'b1;
    dir_row_t    directed_rows [N_DIRECTED];

    capture_apwm_timer_regs DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic capt_out_t apply_timer_item(capt_in_t item);
        capt_out_t   res;
        logic [15:0] lo;
        logic        apwm;
        res = '0;
        lo = item.write_data[15:0];
        apwm = pr_ctl2[CTL2_APWM_BIT];
        case (item.op)
            OP_TICK:
            begin
                if (apwm)
                begin
                    if (pr_ctl2[CTL2_RUN_BIT])
                    begin
                        pr_cnt = pr_cnt + 32'd1;
                        // compare match is checked before period match clears the counter
                        if (pr_cnt == pr_cap[3] && !pr_flags[EV_CMP_BIT])
                        begin
                            pr_flags[EV_CMP_BIT] = 1'b1;
                            if (pr_ien[EV_CMP_BIT])
                                res.irq_pulse = 1'b1;
                        end
                        if (pr_cnt == pr_cap[2] && !pr_flags[EV_PRD_BIT])
                        begin
                            pr_flags[EV_PRD_BIT] = 1'b1;
                            pr_cnt = '0;
                            if (pr_ien[EV_PRD_BIT])
                                res.irq_pulse = 1'b1;
                        end
                        if ((pr_force & pr_ien & EV_APWM_MASK) != '0)
                            res.irq_pulse = 1'b1;
                    end
                end
                else
                begin
                    if ((pr_force & pr_ien & EV_CEVT_MASK) != '0)
                        res.irq_pulse = 1'b1;
                    if ((pr_force[EV_OVF_BIT] || pr_cnt == CNT_ALL_ONES) && pr_ien[EV_OVF_BIT])
                        res.irq_pulse = 1'b1;
                end
            end
            OP_READ:
            begin
                case (item.reg_index)
                    REG_COUNTER:  res.read_data = pr_cnt;
                    REG_PHASE:    res.read_data = pr_phase;
                    REG_CAP1:     res.read_data = pr_cap[0];
                    REG_CAP2:     res.read_data = pr_cap[1];
                    REG_CAP3:     res.read_data = pr_cap[2];
                    REG_CAP4:     res.read_data = pr_cap[3];
                    REG_CTL1:     res.read_data = {16'h0, pr_ctl1};
                    REG_CTL2:     res.read_data = {16'h0, pr_ctl2};
                    REG_INTEN:    res.read_data = {16'h0, pr_ien};
                    REG_FLAGS:    res.read_data = {16'h0, pr_flags};
                    REG_CLEAR:    res.read_data = {16'h0, pr_clear};
                    REG_FORCE:    res.read_data = {16'h0, pr_force};
                    REG_REVISION: res.read_data = pr_rev;
                    default:      res.bad_index = 1'b1;
                endcase
            end
            OP_WRITE:
            begin
                // in apwm mode the capture pairs mirror each other
                case (item.reg_index)
                    REG_COUNTER: pr_cnt = item.write_data;
                    REG_PHASE:   pr_phase = item.write_data;
                    REG_CAP1:
                    begin
                        pr_cap[0] = item.write_data;
                        if (apwm)
                            pr_cap[2] = item.write_data;
                    end
                    REG_CAP2:
                    begin
                        pr_cap[1] = item.write_data;
                        if (apwm)
                            pr_cap[3] = item.write_data;
                    end
                    REG_CAP3:
                    begin
                        pr_cap[2] = item.write_data;
                        if (apwm)
                            pr_cap[0] = item.write_data;
                    end
                    REG_CAP4:
                    begin
                        pr_cap[3] = item.write_data;
                        if (apwm)
                            pr_cap[1] = item.write_data;
                    end
                    REG_CTL1:    pr_ctl1 = lo;
                    REG_CTL2:    pr_ctl2 = lo;
                    REG_INTEN:   pr_ien = lo;
                    REG_FLAGS:   pr_flags = lo;
                    REG_CLEAR:
                    begin
                        pr_clear = lo;
                        pr_flags = pr_flags & ~lo;
                    end
                    REG_FORCE:   pr_force = lo;
                    default:     res.bad_index = 1'b1;
                endcase
            end
            default: ;
        endcase
        return res;
    endfunction

    // mostly well-formed timer traffic with small compare and period values
    function automatic capt_in_t random_item();
        capt_in_t    it;
        logic [15:0] ctl;
        int          pick;
        it.op = OP_TICK;
        it.reg_index = 4'($urandom_range(0, 15));
        it.write_data = $urandom();
        pick = $urandom_range(0, 99);
        if (pick < 50)
            it.op = OP_TICK;
        else if (pick < 63)
            it.op = OP_READ;
        else if (pick < 95)
        begin
            it.op = OP_WRITE;
            it.reg_index = 4'($urandom_range(REG_COUNTER, REG_FORCE));
            case (it.reg_index)
                REG_COUNTER:
                begin
                    pick = $urandom_range(0, 2);
                    if (pick == 0)
                        it.write_data = 32'($urandom_range(0, 8));
                    else if (pick == 1)
                        it.write_data = CNT_ALL_ONES - 32'($urandom_range(0, 3));
                end
                REG_CAP1, REG_CAP2, REG_CAP3, REG_CAP4:
                begin
                    if ($urandom_range(0, 7) != 0)
                        it.write_data = 32'($urandom_range(0, 24));
                end
                REG_CTL2:
                begin
                    ctl = it.write_data[15:0] & ~CTL2_APWM_RUN;
                    if ($urandom_range(0, 4) != 0)
                        ctl[CTL2_APWM_BIT] = 1'b1;
                    if ($urandom_range(0, 5) != 0)
                        ctl[CTL2_RUN_BIT] = 1'b1;
                    it.write_data[15:0] = ctl;
                end
                REG_FORCE:
                begin
                    if ($urandom_range(0, 1) != 0)
                        it.write_data[15:0] = '0;
                end
                default: ;
            endcase
        end
        else if (pick < 98)
        begin
            it.op = OP_WRITE;
            it.reg_index = 4'($urandom_range(REG_REVISION, REG_LAST_HOLE));
        end
        else
            it.op = OP_UNUSED;
        return it;
    endfunction

    task automatic send_item(input capt_in_t item, input logic fixed, input capt_out_t want);
        capt_out_t predicted;
        if (idling && $urandom_range(0, 9) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= item;
        do
            @(posedge clk);
        while (!in_ready);
        predicted = apply_timer_item(item);
        due_results.push_back(fixed ? want : predicted);
    endtask

    // holds off the sender until every result is back, then loads the revision value
    task automatic load_revision(input logic [31:0] value);
        in_valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        pr_rev = value;
    endtask

    task automatic report_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("%0t: %s mismatch, expected %h, got %h", $realtime, field, want, got);
    endtask

    always @(posedge clk)
    begin : sink_idle
        if (sink_hold > 0)
        begin
            sink_hold <= sink_hold - 1;
            out_ready <= 1'b0;
        end
        else if (idling && $urandom_range(0, 19) == 0)
        begin
            sink_hold <= $urandom_range(1, 15) - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin : check_results
        capt_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (due_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: result transfer with nothing expected: %h",
                             $realtime, out_data);
            end
            else
            begin
                want = due_results.pop_front();
                if (out_data.read_data !== want.read_data)
                    report_field("read_data", want.read_data, out_data.read_data);
                if (out_data.irq_pulse !== want.irq_pulse)
                    report_field("irq_pulse", 32'(want.irq_pulse), 32'(out_data.irq_pulse));
                if (out_data.bad_index !== want.bad_index)
                    report_field("bad_index", 32'(want.bad_index), 32'(out_data.bad_index));
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        dir_row_t  row;
        capt_in_t  item;
        capt_out_t want;

        pr_cnt = '0;
        pr_phase = '0;
        pr_cap = '{default: '0};
        pr_ctl1 = '0;
        pr_ctl2 = '0;
        pr_ien = '0;
        pr_flags = '0;
        pr_clear = '0;
        pr_force = '0;
        pr_rev = '0;

        //                 op         index           data                 fix   read     irq   bad
        directed_rows = '{
            '{OP_READ,   REG_COUNTER,  32'h0000_0000,         1'b1, 32'h0, 1'b0, 1'b0},
            '{OP_READ,   REG_REVISION, 32'h0000_0000,         1'b1, CNT_ALL_ONES, 1'b0, 1'b0},
            '{OP_READ,   REG_FIRST_HOLE, 32'h0000_0000,       1'b1, 32'h0, 1'b0, 1'b1},
            '{OP_WRITE,  REG_LAST_HOLE, CNT_ALL_ONES,         1'b1, 32'h0, 1'b0, 1'b1},
            '{OP_WRITE,  REG_REVISION, 32'h0000_0000,         1'b1, 32'h0, 1'b0, 1'b1},
            '{OP_UNUSED, REG_LAST_HOLE, CNT_ALL_ONES,         1'b1, 32'h0, 1'b0, 1'b0},
            '{OP_TICK,   REG_COUNTER,  32'h0000_0000,         1'b1, 32'h0, 1'b0, 1'b0},
            '{OP_WRITE,  REG_COUNTER,  CNT_ALL_ONES,          1'b1, 32'h0, 1'b0, 1'b0},
            '{OP_WRITE,  REG_INTEN,    CNT_ALL_ONES,          1'b1, 32'h0, 1'b0, 1'b0},
            // capture mode with the counter at all ones
            '{OP_TICK,   REG_COUNTER,  32'h0000_0000,         1'b1, 32'h0, 1'b1, 1'b0},
            '{OP_WRITE,  REG_COUNTER,  32'h0000_0000,         1'b1, 32'h0, 1'b0, 1'b0},
            '{OP_WRITE,  REG_FORCE,    {16'h0, EV_CEVT_MASK}, 1'b0, 32'h0, 1'b0, 1'b0},
            '{OP_TICK,   REG_COUNTER,  32'h0000_0000,         1'b1, 32'h0, 1'b1, 1'b0},
            '{OP_WRITE,  REG_FORCE,    32'h0000_0000,         1'b0, 32'h0, 1'b0, 1'b0},
            '{OP_WRITE,  REG_CTL2,     {16'h0, CTL2_APWM_RUN}, 1'b0, 32'h0, 1'b0, 1'b0},
            // mirrored capture writes set up period 3 and compare 2
            '{OP_WRITE,  REG_CAP1,     32'h0000_0003,         1'b0, 32'h0, 1'b0, 1'b0},
            '{OP_WRITE,  REG_CAP4,     32'h0000_0002,         1'b0, 32'h0, 1'b0, 1'b0},
            '{OP_READ,   REG_CAP3,     32'h0000_0000,         1'b0, 32'h0, 1'b0, 1'b0},
            '{OP_TICK,   REG_COUNTER,  32'h0000_0000,         1'b0, 32'h0, 1'b0, 1'b0},
            '{OP_TICK,   REG_COUNTER,  32'h0000_0000,         1'b0, 32'h0, 1'b0, 1'b0},
            '{OP_TICK,   REG_COUNTER,  32'h0000_0000,         1'b0, 32'h0, 1'b0, 1'b0},
            '{OP_READ,   REG_FLAGS,    32'h0000_0000,         1'b0, 32'h0, 1'b0, 1'b0},
            '{OP_WRITE,  REG_CLEAR,    CNT_ALL_ONES,          1'b0, 32'h0, 1'b0, 1'b0},
            '{OP_WRITE,  REG_CTL1,     CNT_ALL_ONES,          1'b0, 32'h0, 1'b0, 1'b0},
            '{OP_READ,   REG_CTL1,     32'h0000_0000,         1'b0, 32'h0, 1'b0, 1'b0}
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        load_revision(CNT_ALL_ONES);
        for (int i = 0; i < N_DIRECTED; i++)
        begin
            row = directed_rows[i];
            item = '{op: row.op, reg_index: row.reg_index, write_data: row.write_data};
            want = '{read_data: row.read_data, irq_pulse: row.irq_pulse,
                     bad_index: row.bad_index};
            send_item(item, row.fixed, want);
        end

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: load_revision(32'h0000_0000);
                3: load_revision(32'h8000_0001);
                default: load_revision($urandom());
            endcase
            // the closing stretch runs at full rate on both sides
            if (ph == 3)
                idling = 1'b0;
            for (int n = 0; n < N_RANDOM_PHASE; n++)
                send_item(random_item(), 1'b0, '0);
        end

        in_valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (mismatches == 0 && due_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### sim.f
design/capt_pkg.sv
design/capture_apwm_timer_regs.sv
tb/capture_apwm_timer_regs_tb.sv
